@@ hw/rtl/ssba_pkg.sv @@
// Shared types and constants for the swap slot bitmap allocator.
`timescale 1ns / 1ps

package ssba_pkg;

   // Default geometry
   localparam int SLOTS_DEF            = 8192;
   localparam int SECTORS_PER_SLOT_DEF = 8;
   localparam int SECTOR_BYTES_DEF     = 512;

   // Bitmap memory word
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   // Result status codes
   localparam logic [1:0] STATUS_XFER     = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [1:0] STATUS_NOT_USED = 2'd2;

   // Request actions
   localparam logic ACTION_SWAP_OUT = 1'b0;
   localparam logic ACTION_SWAP_IN  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [12:0] slot;
      logic [31:0] buffer_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] slot_used;
      logic [15:0] sector;
      logic [31:0] mem_address;
      logic        is_write;
      logic        last;
   } rsp_type;

endpackage

@@ hw/rtl/ssba_first_zero.sv @@
// Lowest clear bit finder over one bitmap word.
`timescale 1ns / 1ps

module ssba_first_zero (
   input  logic [ssba_pkg::WORD_BITS-1:0] word_bits,
   output logic                           found,
   output logic [ssba_pkg::BIT_W-1:0]     index
);
   import ssba_pkg::*;

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word_bits[i]) begin
            found = 1'b1;
            index = BIT_W'(i);
         end
      end
   end

endmodule

@@ hw/rtl/swap_slot_bitmap_allocator.sv @@
// Top level: first-fit swap slot allocator over an occupancy bitmap memory.
`timescale 1ns / 1ps

// Usage
//  Request channel: a word on req_data is taken at a rising edge with start high
//  and busy low. Swap out (action 0) takes the lowest free slot; swap in
//  (action 1) releases the named slot if it is in use.
//  Response channel: each word is on rsp_data for one cycle with rsp_strobe high;
//  the receiver cannot stall, so there is no back-pressure. A transfer gives
//  SECTORS_PER_SLOT words, an error gives one; last marks the final word.
//  The bitmap lives in a memory of 32-bit words with a registered read; a flag
//  per word marks it full, and the flags are scanned 32 at a time for first fit.
//  Sequence: swap out scans the full flags a group at a time for first fit,
//  then does a read/modify/write of the chosen word, then the words stream
//  out one a cycle. Swap in reads the named word before the words. busy
//  stays high until the last word has gone, so one request is handled at a
//  time.
//  Reset: a clearing pass writes every bitmap word, one per cycle, with busy
//  held high; then all slots are free.
module swap_slot_bitmap_allocator #(
   parameter int SLOTS            = ssba_pkg::SLOTS_DEF,
   parameter int SECTORS_PER_SLOT = ssba_pkg::SECTORS_PER_SLOT_DEF,
   parameter int SECTOR_BYTES     = ssba_pkg::SECTOR_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssba_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ssba_pkg::rsp_type rsp_data
);
   import ssba_pkg::*;

   localparam int WORDS     = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int GROUPS    = (WORDS + WORD_BITS - 1) / WORD_BITS;
   localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int FULL_BITS = GROUPS * WORD_BITS;
   localparam int CNT_W     = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
   localparam int SW        = WIDX_W + BIT_W;

   // flags beyond the last real word read as full
   localparam logic [FULL_BITS-1:0] FULL_RST = {FULL_BITS{1'b1}} << WORDS;
   // slots past the end of the last word are held as used
   localparam logic [WORD_BITS-1:0] LAST_PAD =
      {WORD_BITS{1'b1}} << (SLOTS - (WORDS - 1) * WORD_BITS);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_MODIFY = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   // bitmap memory
   logic [WORD_BITS-1:0] bitmap_mem [0:WORDS-1];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WIDX_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [WIDX_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   state_type            state_ff, state_in;
   logic [WIDX_W-1:0]    clr_ff, clr_in;
   logic [FULL_BITS-1:0] full_ff, full_in;
   logic [GRP_W-1:0]     grp_ff, grp_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 single_ff, single_in;
   logic                 action_ff, action_in;
   logic [WIDX_W-1:0]    widx_ff, widx_in;
   logic [BIT_W-1:0]     bidx_ff, bidx_in;
   logic [12:0]          slot_req_ff, slot_req_in;
   logic [1:0]           status_ff, status_in;
   logic                 is_write_ff, is_write_in;
   logic [12:0]          slot_used_ff, slot_used_in;
   logic [15:0]          sector_ff, sector_in;
   logic [31:0]          addr_ff, addr_in;

   logic                 grp_found;
   logic [BIT_W-1:0]     grp_index;
   logic                 bit_found;
   logic [BIT_W-1:0]     bit_index;
   logic [SW-1:0]        slot_num;
   logic                 last_word;

   // first non-full word within the current group of flags
   ssba_first_zero u_grp_zero (
      .word_bits (full_ff[{grp_ff, {BIT_W{1'b0}}} +: WORD_BITS]),
      .found     (grp_found),
      .index     (grp_index)
   );

   // first free slot within the word just read
   ssba_first_zero u_bit_zero (
      .word_bits (rd_data_ff),
      .found     (bit_found),
      .index     (bit_index)
   );

   assign last_word = single_ff || (cnt_ff == CNT_W'(SECTORS_PER_SLOT - 1));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      full_in      = full_ff;
      grp_in       = grp_ff;
      cnt_in       = cnt_ff;
      single_in    = single_ff;
      action_in    = action_ff;
      widx_in      = widx_ff;
      bidx_in      = bidx_ff;
      slot_req_in  = slot_req_ff;
      status_in    = status_ff;
      is_write_in  = is_write_ff;
      slot_used_in = slot_used_ff;
      sector_in    = sector_ff;
      addr_in      = addr_ff;
      rd_addr      = widx_ff;
      wr_en        = 1'b0;
      wr_addr      = widx_ff;
      wr_data      = rd_data_ff;
      slot_num     = {widx_ff, bidx_ff};

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == WIDX_W'(WORDS - 1)) ? LAST_PAD : '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == WIDX_W'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               action_in   = req_data.action;
               slot_req_in = req_data.slot;
               addr_in     = req_data.buffer_address;
               widx_in     = WIDX_W'(req_data.slot >> BIT_W);
               bidx_in     = req_data.slot[BIT_W-1:0];
               rd_addr     = WIDX_W'(req_data.slot >> BIT_W);
               cnt_in      = '0;
               single_in   = 1'b0;
               status_in   = STATUS_XFER;
               if (req_data.action == ACTION_SWAP_OUT) begin
                  is_write_in = 1'b1;
                  grp_in      = '0;
                  state_in    = S_SCAN;
               end else begin
                  is_write_in = 1'b0;
                  if (32'(req_data.slot) >= 32'(SLOTS)) begin
                     // slot off the end of the map: never in use
                     status_in    = STATUS_NOT_USED;
                     slot_used_in = req_data.slot;
                     sector_in    = '0;
                     addr_in      = '0;
                     single_in    = 1'b1;
                     state_in     = S_EMIT;
                  end else begin
                     state_in = S_MODIFY;
                  end
               end
            end
         end

         S_SCAN: begin
            if (grp_found) begin
               widx_in  = WIDX_W'({grp_ff, grp_index});
               rd_addr  = WIDX_W'({grp_ff, grp_index});
               state_in = S_MODIFY;
            end else if (grp_ff == GRP_W'(GROUPS - 1)) begin
               status_in    = STATUS_NO_FREE;
               slot_used_in = '0;
               sector_in    = '0;
               addr_in      = '0;
               single_in    = 1'b1;
               state_in     = S_EMIT;
            end else begin
               grp_in = grp_ff + 1'b1;
            end
         end

         S_MODIFY: begin
            state_in = S_EMIT;
            if (action_ff == ACTION_SWAP_OUT) begin
               // flag said not full, so a clear bit exists
               slot_num          = {widx_ff, bit_index};
               wr_en             = bit_found;
               wr_data           = rd_data_ff | (WORD_BITS'(1) << bit_index);
               full_in[widx_ff]  = &wr_data;
               slot_used_in      = 13'(slot_num);
               sector_in         = 16'(32'(slot_num) * 32'(SECTORS_PER_SLOT));
            end else if (rd_data_ff[bidx_ff]) begin
               wr_en             = 1'b1;
               wr_data           = rd_data_ff & ~(WORD_BITS'(1) << bidx_ff);
               full_in[widx_ff]  = 1'b0;
               slot_used_in      = slot_req_ff;
               sector_in         = 16'(32'(slot_num) * 32'(SECTORS_PER_SLOT));
            end else begin
               status_in    = STATUS_NOT_USED;
               slot_used_in = slot_req_ff;
               sector_in    = '0;
               addr_in      = '0;
               single_in    = 1'b1;
            end
         end

         S_EMIT: begin
            cnt_in    = cnt_ff + 1'b1;
            sector_in = sector_ff + 16'd1;
            addr_in   = addr_ff + 32'(SECTOR_BYTES);
            if (last_word) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         full_ff   <= FULL_RST;
         grp_ff    <= '0;
         cnt_ff    <= '0;
         single_ff <= 1'b0;
         action_ff <= ACTION_SWAP_OUT;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         full_ff   <= full_in;
         grp_ff    <= grp_in;
         cnt_ff    <= cnt_in;
         single_ff <= single_in;
         action_ff <= action_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      widx_ff      <= widx_in;
      bidx_ff      <= bidx_in;
      slot_req_ff  <= slot_req_in;
      status_ff    <= status_in;
      is_write_ff  <= is_write_in;
      slot_used_ff <= slot_used_in;
      sector_ff    <= sector_in;
      addr_ff      <= addr_in;
   end

   // bitmap memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= bitmap_mem[rd_addr];
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = (state_ff == S_EMIT);
   assign rsp_data.status      = status_ff;
   assign rsp_data.slot_used   = slot_used_ff;
   assign rsp_data.sector      = sector_ff;
   assign rsp_data.mem_address = addr_ff;
   assign rsp_data.is_write    = is_write_ff;
   assign rsp_data.last        = last_word;

endmodule

@@ tb/tb_swap_slot_bitmap_allocator.sv @@
// Self-checking testbench for the first-fit swap slot bitmap allocator.
`timescale 1ns / 1ps

module tb_swap_slot_bitmap_allocator;
   import ssba_pkg::*;

   // Geometry as built into the block by default
   localparam int SLOTS        = SLOTS_DEF;
   localparam int SECTORS      = SECTORS_PER_SLOT_DEF;
   localparam int SECTOR_BYTES = SECTOR_BYTES_DEF;

   // Cycle budget: many times the slowest correct run (about 210 requests with
   // pauses between them, and the clearing pass).
   localparam int CYCLE_LIMIT = 100_000;
   // Quiet cycles after the last expected word before the verdict
   localparam int TAIL_CYCLES = 40;

   // One queued request word with its issue hints
   typedef struct {
      req_type word;
      bit      pick_live;   // replace slot with one that is in use at issue time
      bit      may_idle;    // driver may pause after this word is taken
   } pending_req_type;

   logic    clock;
   logic    reset;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   swap_slot_bitmap_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Predictor state: our own occupancy map, a list of slots in use (for
   // picking swap-in targets) and a lower bound on the first free slot, so
   // the first-fit search does not rescan the whole map every time.
   // ---------------------------------------------------------------------
   bit              occupied [SLOTS];
   int              live_slots [$];
   int              free_hint = 0;
   rsp_type         expected_words [$];
   pending_req_type pending_reqs [$];
   int              errors = 0;
   int              cycles = 0;
   int              idle_left = 0;
   bit              cur_may_idle = 1'b0;

   // Sector command words for one page: write on swap out, read on swap in
   task automatic push_sector_cmds(int s, logic [31:0] base, bit wr);
      rsp_type w;
      for (int i = 0; i < SECTORS; i++) begin
         w.status      = STATUS_XFER;
         w.slot_used   = 13'(s);
         w.sector      = 16'(s * SECTORS + i);
         w.mem_address = base + 32'(SECTOR_BYTES * i);   // wraps mod 2^32
         w.is_write    = wr;
         w.last        = (i == SECTORS - 1);
         expected_words.push_back(w);
      end
   endtask

   // Work out the words that one accepted request causes, updating the map
   task automatic predict_sector_cmds(req_type r);
      rsp_type w;
      int      s;
      w = '0;
      w.last = 1'b1;
      if (r.action == ACTION_SWAP_OUT) begin
         while (free_hint < SLOTS && occupied[free_hint]) free_hint++;
         if (free_hint >= SLOTS) begin
            // map full: single error word, map untouched
            w.status   = STATUS_NO_FREE;
            w.is_write = 1'b1;
            expected_words.push_back(w);
         end else begin
            s = free_hint;
            occupied[s] = 1'b1;
            live_slots.push_back(s);
            push_sector_cmds(s, r.buffer_address, 1'b1);
         end
      end else begin
         s = int'(r.slot);
         if (!occupied[s]) begin
            // swap in of a free slot: error word naming the slot
            w.status    = STATUS_NOT_USED;
            w.slot_used = r.slot;
            expected_words.push_back(w);
         end else begin
            push_sector_cmds(s, r.buffer_address, 1'b0);
            occupied[s] = 1'b0;
            if (s < free_hint) free_hint = s;
            for (int k = 0; k < live_slots.size(); k++) begin
               if (live_slots[k] == s) begin
                  live_slots.delete(k);
                  break;
               end
            end
         end
      end
   endtask

   task automatic queue_req(bit action, int slot, logic [31:0] base, bit pick, bit may_idle);
      pending_req_type p;
      p.word.action         = action;
      p.word.slot           = 13'(slot);
      p.word.buffer_address = base;
      p.pick_live           = pick;
      p.may_idle            = may_idle;
      pending_reqs.push_back(p);
   endtask

   // Random page address, now and then placed so the sector addresses wrap
   function automatic logic [31:0] rand_base();
      if ($urandom_range(0, 7) == 0) return 32'hFFFF_F000 | 32'($urandom_range(0, 4095));
      return $urandom;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset, cycle budget
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached", $time);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: a word is taken at an edge with start high and busy low. While
   // a word waits, start and req_data hold. Between words the driver may
   // pause for a random burst, so start rises at any point of the block's
   // work, including mid-transfer while busy is still high.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      pending_req_type p;
      req_type         w;
      if (reset) begin
         start     <= 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy) begin
            predict_sector_cmds(req_data);
            if (cur_may_idle && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 18);
         end
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               p = pending_reqs.pop_front();
               w = p.word;
               if (p.pick_live && live_slots.size() > 0)
                  w.slot = 13'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
               req_data     <= w;
               start        <= 1'b1;
               cur_may_idle = p.may_idle;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobed word must match the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_words.pop_front();
            check_field("status",      32'(want.status),      32'(rsp_data.status));
            check_field("slot_used",   32'(want.slot_used),   32'(rsp_data.slot_used));
            check_field("sector",      32'(want.sector),      32'(rsp_data.sector));
            check_field("mem_address", want.mem_address,      rsp_data.mem_address);
            check_field("is_write",    32'(want.is_write),    32'(rsp_data.is_write));
            check_field("last",        32'(want.last),        32'(rsp_data.last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic drain();
      while (pending_reqs.size() != 0 || start || expected_words.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int r;

      // Directed: swap in of free slots at both ends, first fit into holes,
      // address wrap, double release
      queue_req(ACTION_SWAP_IN,  0,     32'h0000_0000, 0, 1);
      queue_req(ACTION_SWAP_IN,  8191,  32'hFFFF_FFFF, 0, 1);
      queue_req(ACTION_SWAP_OUT, 8191,  32'h0000_0000, 0, 1);   // slot field ignored
      queue_req(ACTION_SWAP_OUT, 0,     32'hFFFF_FFFF, 0, 1);
      queue_req(ACTION_SWAP_OUT, 4660,  32'hFFFF_F200, 0, 1);
      queue_req(ACTION_SWAP_OUT, 0,     32'h1234_5678, 0, 1);
      queue_req(ACTION_SWAP_IN,  1,     32'hFFFF_FFFF, 0, 1);
      queue_req(ACTION_SWAP_IN,  1,     32'hAAAA_5555, 0, 1);   // already released
      queue_req(ACTION_SWAP_OUT, 5461,  32'h0000_0000, 0, 1);   // fills hole at 1
      queue_req(ACTION_SWAP_IN,  0,     32'h8000_0000, 0, 1);
      queue_req(ACTION_SWAP_IN,  2,     32'h7FFF_FFFF, 0, 1);
      queue_req(ACTION_SWAP_OUT, 0,     32'h5555_AAAA, 0, 1);
      queue_req(ACTION_SWAP_OUT, 0,     32'hFFFF_FE00, 0, 1);
      queue_req(ACTION_SWAP_IN,  3,     32'h0000_0001, 0, 1);
      queue_req(ACTION_SWAP_IN,  3,     32'h0000_0001, 0, 1);
      queue_req(ACTION_SWAP_IN,  4,     32'hDEAD_BEEF, 0, 1);   // never used
      queue_req(ACTION_SWAP_IN,  4096,  32'h0000_0000, 0, 1);

      // Random: mostly allocate/release pairs on live slots, some noise
      for (int n = 0; n < 150; n++) begin
         r = $urandom_range(0, 99);
         if (r < 50)      queue_req(ACTION_SWAP_OUT, $urandom_range(0, 8191), rand_base(), 0, 1);
         else if (r < 80) queue_req(ACTION_SWAP_IN, 0, rand_base(), 1, 1);
         else if (r < 95) queue_req(ACTION_SWAP_IN, $urandom_range(0, 8191), rand_base(), 0, 1);
         else             queue_req(ACTION_SWAP_IN, $urandom_range(0, 31), rand_base(), 0, 1);
      end
      drain();

      // No pauses from here on: top slot round trip, then random traffic
      queue_req(ACTION_SWAP_IN,  8191, 32'hFFFF_FFFF, 0, 0);
      queue_req(ACTION_SWAP_OUT, 0,    32'h0000_0000, 0, 0);
      queue_req(ACTION_SWAP_OUT, 0,    32'h0000_0000, 0, 0);
      queue_req(ACTION_SWAP_IN,  0,    32'hFFFF_FF00, 0, 0);
      queue_req(ACTION_SWAP_OUT, 8191, 32'h0000_0100, 0, 0);
      for (int n = 0; n < 40; n++) begin
         r = $urandom_range(0, 99);
         if (r < 40)      queue_req(ACTION_SWAP_OUT, $urandom_range(0, 8191), rand_base(), 0, 0);
         else if (r < 80) queue_req(ACTION_SWAP_IN, 0, rand_base(), 1, 0);
         else             queue_req(ACTION_SWAP_IN, $urandom_range(0, 8191), rand_base(), 0, 0);
      end
      drain();

      // Let any stray word show up before the verdict
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
